// ----- rtl/source_text_tokenizer_top_macros.svh -----
// ----------------------------------------------------------------------------
// source_text_tokenizer_top_macros
// assertion macros shared by the tokenizer rtl
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_TOP_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_TOP_MACROS_SVH
`ifndef SYNTH
`define STT_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");
`define STT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define STT_ASSERT_NEVER(label, clk, rst, expr)
`define STT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg
// types and constants of the source text tokenizer
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int OFFSET_BITS_DEF = 16;
   localparam int LINE_BITS_DEF   = 16;
   localparam int MAX_RES         = 3;
   localparam int FIFO_DEPTH      = 8;
   localparam int PTR_W           = 3;
   localparam int CNT_W           = 4;

   typedef enum logic [3:0] {
      M_IDLE    = 4'd0,
      M_IDENT   = 4'd1,
      M_SIGN    = 4'd2,
      M_ZERO    = 4'd3,
      M_DEC     = 4'd4,
      M_BIN     = 4'd5,
      M_HEX     = 4'd6,
      M_STR     = 4'd7,
      M_STRDONE = 4'd8,
      M_COLON   = 4'd9,
      M_DOT     = 4'd10
   } scan_mode_type;

   localparam logic [4:0] K_END    = 5'd0;
   localparam logic [4:0] K_IDENT  = 5'd1;
   localparam logic [4:0] K_DEC    = 5'd2;
   localparam logic [4:0] K_FLOAT  = 5'd3;
   localparam logic [4:0] K_BIN    = 5'd4;
   localparam logic [4:0] K_HEX    = 5'd5;
   localparam logic [4:0] K_STRING = 5'd6;
   localparam logic [4:0] K_AT     = 5'd7;
   localparam logic [4:0] K_LPAREN = 5'd8;
   localparam logic [4:0] K_RPAREN = 5'd9;
   localparam logic [4:0] K_LBRACE = 5'd10;
   localparam logic [4:0] K_RBRACE = 5'd11;
   localparam logic [4:0] K_SEMI   = 5'd12;
   localparam logic [4:0] K_EQ     = 5'd13;
   localparam logic [4:0] K_COMMA  = 5'd14;
   localparam logic [4:0] K_COLON  = 5'd15;
   localparam logic [4:0] K_DCOLON = 5'd16;
   localparam logic [4:0] K_DOT    = 5'd17;
   localparam logic [4:0] K_ELLIP  = 5'd18;
   localparam logic [4:0] K_MINUS  = 5'd19;
   localparam logic [4:0] K_ARROW  = 5'd20;
   localparam logic [4:0] K_UNEXP  = 5'd21;
   localparam logic [4:0] K_UNTERM = 5'd22;
   localparam logic [4:0] K_NORADX = 5'd23;

   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   typedef struct packed {
      logic        fin;
      logic [15:0] col;
      logic [15:0] line;
      logic [15:0] end_off;
      logic [15:0] start_off;
      logic [4:0]  kind;
   } rsp_item_type;

endpackage

// ----- rtl/source_text_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// source_text_tokenizer_top
// streaming lexer: one source byte per transfer in, one token record per
// transfer out
// ----------------------------------------------------------------------------
// channel  dir  tdata                                   tlast
// req      in   data_byte[7:0]                          end_marker
// rsp      out  kind,start,end,line,column (69 of 72)   final_token
//
// one byte per cycle while req_tready is high: a byte is registered, scanned in the
// next cycle and its zero to three records land in an eight entry queue
// req_tready is high while the queue holds at most two records
// a byte that closes two tokens and ends the text yields three records
// reset returns the scanner to the state between tokens and empties the queue
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_top_macros.svh"

module source_text_tokenizer_top #(
   parameter int OffsetBits = stt_pkg::OFFSET_BITS_DEF,
   parameter int LineBits   = stt_pkg::LINE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tlast,   // end_marker
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // token_kind[4:0], start_offset[20:5], end_offset[36:21],
                                    // line_number[52:37], start_column[68:53], zero
   output logic        rsp_tlast    // final_token
);

   typedef logic [OffsetBits-1:0] off_type;
   typedef logic [LineBits-1:0]   lc_type;

   localparam off_type OffMax = {OffsetBits{1'b1}};
   localparam lc_type  LcMax  = {LineBits{1'b1}};

   // input register
   logic       stg_valid_ff;
   logic [7:0] stg_byte_ff;
   logic       stg_end_ff;

   // scanner state
   stt_pkg::scan_mode_type mode_ff, mode_in;
   off_type    offset_ff, offset_in;
   lc_type     line_ff, line_in;
   lc_type     col_ff, col_in;
   off_type    tstart_ff, tstart_in;
   lc_type     tcol_ff, tcol_in;
   lc_type     tline_ff, tline_in;
   logic [7:0] sign_ff, sign_in;
   logic [1:0] dots_ff, dots_in;
   logic       seen_dot_ff, seen_dot_in;
   logic       radix_seen_ff, radix_seen_in;

   // result queue
   stt_pkg::rsp_item_type             queue_ff [stt_pkg::FIFO_DEPTH];
   logic [stt_pkg::PTR_W-1:0]         wr_ptr_ff, rd_ptr_ff;
   logic [stt_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   stt_pkg::rsp_item_type             res [stt_pkg::MAX_RES];
   logic [1:0]                        nres;
   logic                              pop;

   function automatic off_type sat_off(input off_type v);
      sat_off = (v == OffMax) ? v : v + 1'b1;
   endfunction

   function automatic lc_type sat_lc(input lc_type v);
      sat_lc = (v == LcMax) ? v : v + 1'b1;
   endfunction

   function automatic stt_pkg::rsp_item_type mk(input logic [4:0] kind, input off_type s,
                                                input off_type e, input lc_type ln,
                                                input lc_type cl, input logic fin);
      logic [31:0] ws, we, wl, wc;
      ws = 32'(s);
      we = 32'(e);
      wl = 32'(ln);
      wc = 32'(cl);
      mk.kind      = kind;
      mk.start_off = ws[15:0];
      mk.end_off   = we[15:0];
      mk.line      = wl[15:0];
      mk.col       = wc[15:0];
      mk.fin       = fin;
   endfunction

   assign req_tready = (cnt_ff <= stt_pkg::CNT_W'(stt_pkg::FIFO_DEPTH - 2 * stt_pkg::MAX_RES));

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= req_tvalid && req_tready;
      end
      stg_byte_ff <= req_tdata;
      stg_end_ff  <= req_tlast;
   end

   always_comb begin
      logic    eof, isd, isa, iss, ish, rescan, do_dec, digit_ok;
      logic [7:0] b;
      off_type p, last;
      logic [4:0] k;

      b   = stg_byte_ff;
      eof = stg_end_ff;
      isd = !eof && (b >= stt_pkg::CH_ZERO) && (b <= 8'h39);
      isa = !eof && (((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)));
      iss = !eof && ((b == stt_pkg::CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D)));
      ish = isd || (!eof && (((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46))));

      mode_in       = mode_ff;
      offset_in     = offset_ff;
      line_in       = line_ff;
      col_in        = col_ff;
      tstart_in     = tstart_ff;
      tcol_in       = tcol_ff;
      tline_in      = tline_ff;
      sign_in       = sign_ff;
      dots_in       = dots_ff;
      seen_dot_in   = seen_dot_ff;
      radix_seen_in = radix_seen_ff;
      nres          = 2'd0;
      rescan        = 1'b0;
      do_dec        = 1'b0;
      digit_ok      = 1'b0;
      k             = stt_pkg::K_UNEXP;
      for (int i = 0; i < stt_pkg::MAX_RES; i++) begin
         res[i] = '0;
      end

      p    = offset_ff;
      last = (p != '0) ? p - 1'b1 : '0;

      // position counters move on every byte after the first
      if (p != '0) begin
         if (!eof && (b == stt_pkg::CH_NL)) begin
            line_in = sat_lc(line_ff);
            col_in  = '0;
         end else begin
            col_in = sat_lc(col_ff);
         end
      end

      case (mode_ff)
         stt_pkg::M_IDENT: begin
            if (!(isa || isd || (!eof && b == stt_pkg::CH_UNDER))) begin
               res[nres] = mk(stt_pkg::K_IDENT, tstart_ff, last, line_in, tcol_ff, 1'b0);
               nres = nres + 1'b1;
               rescan = 1'b1;
            end
         end
         stt_pkg::M_SIGN: begin
            if (isd) begin
               seen_dot_in = 1'b0;
               mode_in = (b == stt_pkg::CH_ZERO) ? stt_pkg::M_ZERO : stt_pkg::M_DEC;
            end else if ((sign_ff == stt_pkg::CH_MINUS) && !eof && (b == stt_pkg::CH_GT)) begin
               res[nres] = mk(stt_pkg::K_ARROW, tstart_ff, p, tline_ff, tcol_ff, 1'b0);
               nres = nres + 1'b1;
               mode_in = stt_pkg::M_IDLE;
            end else begin
               res[nres] = mk((sign_ff == stt_pkg::CH_MINUS) ? stt_pkg::K_MINUS
                              : stt_pkg::K_UNEXP, tstart_ff, tstart_ff, tline_ff, tcol_ff, 1'b0);
               nres = nres + 1'b1;
               rescan = 1'b1;
            end
         end
         stt_pkg::M_ZERO: begin
            if (!eof && b == stt_pkg::CH_B) begin
               radix_seen_in = 1'b0;
               mode_in = stt_pkg::M_BIN;
            end else if (!eof && b == stt_pkg::CH_X) begin
               radix_seen_in = 1'b0;
               mode_in = stt_pkg::M_HEX;
            end else begin
               mode_in = stt_pkg::M_DEC;
               do_dec = 1'b1;
            end
         end
         stt_pkg::M_DEC: begin
            do_dec = 1'b1;
         end
         stt_pkg::M_BIN, stt_pkg::M_HEX: begin
            digit_ok = (mode_ff == stt_pkg::M_BIN)
                       ? (!eof && (b == stt_pkg::CH_ZERO || b == stt_pkg::CH_ONE)) : ish;
            if (digit_ok) begin
               radix_seen_in = 1'b1;
            end else begin
               if (!radix_seen_ff) k = stt_pkg::K_NORADX;
               else if (mode_ff == stt_pkg::M_BIN) k = stt_pkg::K_BIN;
               else k = stt_pkg::K_HEX;
               res[nres] = mk(k, tstart_ff, last, line_in, tcol_ff, 1'b0);
               nres = nres + 1'b1;
               rescan = 1'b1;
            end
         end
         stt_pkg::M_STR: begin
            if (!eof && b == stt_pkg::CH_QUOTE) begin
               mode_in = stt_pkg::M_STRDONE;
            end else if (eof || b == stt_pkg::CH_NL) begin
               res[nres] = mk(stt_pkg::K_UNTERM, sat_off(tstart_ff), last, line_in, col_in, 1'b0);
               nres = nres + 1'b1;
               rescan = 1'b1;
            end
         end
         stt_pkg::M_STRDONE: begin
            res[nres] = mk(stt_pkg::K_STRING, tstart_ff, last, line_in, tcol_ff, 1'b0);
            nres = nres + 1'b1;
            rescan = 1'b1;
         end
         stt_pkg::M_COLON: begin
            if (!eof && b == stt_pkg::CH_COLON) begin
               res[nres] = mk(stt_pkg::K_DCOLON, tstart_ff, p, tline_ff, tcol_ff, 1'b0);
               nres = nres + 1'b1;
               mode_in = stt_pkg::M_IDLE;
            end else begin
               res[nres] = mk(stt_pkg::K_COLON, tstart_ff, tstart_ff, tline_ff, tcol_ff, 1'b0);
               nres = nres + 1'b1;
               rescan = 1'b1;
            end
         end
         stt_pkg::M_DOT: begin
            if (!eof && b == stt_pkg::CH_DOT) begin
               if (dots_ff < 2'd2) begin
                  dots_in = 2'd2;
               end else begin
                  res[nres] = mk(stt_pkg::K_ELLIP, tstart_ff, p, tline_ff, tcol_ff, 1'b0);
                  nres = nres + 1'b1;
                  mode_in = stt_pkg::M_IDLE;
               end
            end else begin
               res[nres] = mk(stt_pkg::K_DOT, tstart_ff, tstart_ff, tline_ff, tcol_ff, 1'b0);
               nres = nres + 1'b1;
               // two dots with no third: second dot is its own token
               if (dots_ff >= 2'd2) begin
                  res[nres] = mk(stt_pkg::K_DOT, sat_off(tstart_ff), sat_off(tstart_ff),
                                 tline_ff, sat_lc(tcol_ff), 1'b0);
                  nres = nres + 1'b1;
               end
               rescan = 1'b1;
            end
         end
         default: begin
            rescan = 1'b1;
         end
      endcase

      if (do_dec) begin
         if (isd) begin
            mode_in = stt_pkg::M_DEC;
         end else if (!eof && b == stt_pkg::CH_DOT) begin
            seen_dot_in = 1'b1;
         end else begin
            res[nres] = mk(seen_dot_ff ? stt_pkg::K_FLOAT : stt_pkg::K_DEC, tstart_ff, last,
                           line_in, tcol_ff, 1'b0);
            nres = nres + 1'b1;
            rescan = 1'b1;
         end
      end

      // a byte that is not whitespace or the end marker starts a new token from the state between tokens
      if (rescan) begin
         mode_in = stt_pkg::M_IDLE;
         if (!eof && !iss) begin
            tstart_in = p;
            tcol_in   = col_in;
            tline_in  = line_in;
            if (isd) begin
               seen_dot_in = 1'b0;
               mode_in = (b == stt_pkg::CH_ZERO) ? stt_pkg::M_ZERO : stt_pkg::M_DEC;
            end else if (b == stt_pkg::CH_PLUS || b == stt_pkg::CH_MINUS) begin
               sign_in = b;
               mode_in = stt_pkg::M_SIGN;
            end else if (isa || b == stt_pkg::CH_UNDER) begin
               mode_in = stt_pkg::M_IDENT;
            end else if (b == stt_pkg::CH_QUOTE) begin
               mode_in = stt_pkg::M_STR;
            end else if (b == stt_pkg::CH_COLON) begin
               mode_in = stt_pkg::M_COLON;
            end else if (b == stt_pkg::CH_DOT) begin
               dots_in = 2'd1;
               mode_in = stt_pkg::M_DOT;
            end else begin
               case (b)
                  stt_pkg::CH_AT:     k = stt_pkg::K_AT;
                  stt_pkg::CH_LPAREN: k = stt_pkg::K_LPAREN;
                  stt_pkg::CH_RPAREN: k = stt_pkg::K_RPAREN;
                  stt_pkg::CH_LBRACE: k = stt_pkg::K_LBRACE;
                  stt_pkg::CH_RBRACE: k = stt_pkg::K_RBRACE;
                  stt_pkg::CH_SEMI:   k = stt_pkg::K_SEMI;
                  stt_pkg::CH_EQ:     k = stt_pkg::K_EQ;
                  stt_pkg::CH_COMMA:  k = stt_pkg::K_COMMA;
                  default:            k = stt_pkg::K_UNEXP;
               endcase
               res[nres] = mk(k, p, p, line_in, col_in, 1'b0);
               nres = nres + 1'b1;
            end
         end
      end

      if (eof) begin
         res[nres] = mk(stt_pkg::K_END, p, p, line_in, col_in, 1'b1);
         nres = nres + 1'b1;
         mode_in       = stt_pkg::M_IDLE;
         offset_in     = '0;
         line_in       = lc_type'(1);
         col_in        = lc_type'(1);
         tstart_in     = '0;
         tcol_in       = '0;
         tline_in      = '0;
         dots_in       = 2'd0;
         seen_dot_in   = 1'b0;
         radix_seen_in = 1'b0;
      end else begin
         offset_in = sat_off(p);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= stt_pkg::M_IDLE;
         offset_ff     <= '0;
         line_ff       <= lc_type'(1);
         col_ff        <= lc_type'(1);
         tstart_ff     <= '0;
         tcol_ff       <= '0;
         tline_ff      <= '0;
         dots_ff       <= 2'd0;
         seen_dot_ff   <= 1'b0;
         radix_seen_ff <= 1'b0;
      end else if (stg_valid_ff) begin
         mode_ff       <= mode_in;
         offset_ff     <= offset_in;
         line_ff       <= line_in;
         col_ff        <= col_in;
         tstart_ff     <= tstart_in;
         tcol_ff       <= tcol_in;
         tline_ff      <= tline_in;
         dots_ff       <= dots_in;
         seen_dot_ff   <= seen_dot_in;
         radix_seen_ff <= radix_seen_in;
      end
   end

   // sign byte is only read after it has been written
   always_ff @(posedge clock) begin
      if (stg_valid_ff) begin
         sign_ff <= sign_in;
      end
   end

   assign pop    = rsp_tvalid && rsp_tready;
   assign cnt_in = cnt_ff + (stg_valid_ff ? stt_pkg::CNT_W'(nres) : '0)
                   - stt_pkg::CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (stg_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + stt_pkg::PTR_W'(nres);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < stt_pkg::MAX_RES; i++) begin
         if (stg_valid_ff && (2'(i) < nres)) begin
            queue_ff[wr_ptr_ff + stt_pkg::PTR_W'(i)] <= res[i];
         end
      end
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = {3'b000, queue_ff[rd_ptr_ff].col, queue_ff[rd_ptr_ff].line,
                        queue_ff[rd_ptr_ff].end_off, queue_ff[rd_ptr_ff].start_off,
                        queue_ff[rd_ptr_ff].kind};
   assign rsp_tlast  = queue_ff[rd_ptr_ff].fin;

   `STT_ASSERT_NEVER(a_queue_bound, clock, reset, cnt_ff > stt_pkg::CNT_W'(stt_pkg::FIFO_DEPTH))
   `STT_ASSERT_IMPLY(a_ptr_track, clock, reset, 1'b1, rd_ptr_ff + stt_pkg::PTR_W'(cnt_ff) == wr_ptr_ff)
   `STT_ASSERT_IMPLY(a_room_on_accept, clock, reset, req_tvalid && req_tready, cnt_ff <= stt_pkg::CNT_W'(2))
   `STT_ASSERT_IMPLY(a_end_resets, clock, reset, $past(stg_valid_ff && stg_end_ff), offset_ff == '0)

endmodule
